// ===== rtl/core/spsi_pkg.sv =====
// Shared types, constants and lookup functions for the six-position stepper indexer.
// Used by every module in rtl/core; depends on nothing.
`timescale 1ns / 1ps

package spsi_pkg;

    localparam int unsigned PERIOD_W = 16;
    localparam int unsigned POS_W    = 3;
    localparam int unsigned COILS_W  = 4;
    localparam int unsigned STEPS_W  = 12;
    localparam int unsigned PHASE_W  = 3;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1126;
    localparam logic [POS_W-1:0]    POS_RESET    = 3'd1;
    localparam logic [POS_W-1:0]    POS_MIN      = 3'd1;
    localparam logic [POS_W-1:0]    POS_MAX      = 3'd6;
    localparam logic [POS_W-1:0]    POS_COUNT    = 3'd6;
    localparam logic [POS_W-1:0]    HALF_TURN    = 3'd3;
    localparam logic [COILS_W-1:0]  COILS_RESET  = 4'hF;
    localparam logic [PHASE_W-1:0]  PHASE_CW     = 3'd0;
    localparam logic [PHASE_W-1:0]  PHASE_CCW    = 3'd7;

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_MOVE = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [POS_W-1:0] target_position;
    } in_item_t;

    typedef struct packed {
        logic [COILS_W-1:0] coils;
        logic [POS_W-1:0]   position;
        logic               busy_res;
        logic               rejected;
    } out_item_t;

    function automatic logic [COILS_W-1:0] coil_pattern(input logic [PHASE_W-1:0] phase);
        logic [COILS_W-1:0] pat;
        case (phase)
            3'd0:    pat = 4'h1;
            3'd1:    pat = 4'h3;
            3'd2:    pat = 4'h2;
            3'd3:    pat = 4'h6;
            3'd4:    pat = 4'h4;
            3'd5:    pat = 4'hC;
            3'd6:    pat = 4'h8;
            default: pat = 4'h9;
        endcase
        return pat;
    endfunction

    // floor(span * 256 / 3) sequences of eight half steps
    function automatic logic [STEPS_W-1:0] half_steps_for(input logic [1:0] span);
        logic [STEPS_W-1:0] steps;
        case (span)
            2'd1:    steps = 12'd680;
            2'd2:    steps = 12'd1360;
            2'd3:    steps = 12'd2048;
            default: steps = '0;
        endcase
        return steps;
    endfunction

endpackage

// ===== rtl/core/spsi_motion.sv =====
// Motion state and single-pass step logic: period register, position, phase, counters.
// Depends on spsi_pkg.
`timescale 1ns / 1ps

module spsi_motion (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [spsi_pkg::PERIOD_W-1:0]    cfg_wr_data,
    input  logic                             step_en,
    input  spsi_pkg::in_item_t               step_item,
    output spsi_pkg::out_item_t              step_result
);

    logic [spsi_pkg::PERIOD_W-1:0] period_reg;
    logic [spsi_pkg::POS_W-1:0]    current_pos_reg, current_pos_next;
    logic [spsi_pkg::POS_W-1:0]    goal_pos_reg, goal_pos_next;
    logic                          moving_reg, moving_next;
    logic                          turn_cw_reg, turn_cw_next;
    logic [spsi_pkg::PHASE_W-1:0]  phase_reg, phase_next;
    logic [spsi_pkg::STEPS_W-1:0]  steps_left_reg, steps_left_next;
    logic [spsi_pkg::PERIOD_W-1:0] tick_count_reg, tick_count_next;
    logic [spsi_pkg::COILS_W-1:0]  coils_reg, coils_next;

    logic [spsi_pkg::PERIOD_W-1:0] limit;
    logic [spsi_pkg::PERIOD_W-1:0] tick_inc;
    logic [spsi_pkg::STEPS_W-1:0]  steps_dec;
    logic [spsi_pkg::PHASE_W-1:0]  phase_adv;
    logic [spsi_pkg::POS_W-1:0]    target;
    logic [spsi_pkg::POS_W-1:0]    cw_dist;
    logic                          go_cw;
    logic [1:0]                    move_span;
    logic                          rejected;

    assign limit     = (period_reg == '0) ? 16'd1 : period_reg;
    assign tick_inc  = tick_count_reg + 16'd1;
    assign steps_dec = steps_left_reg - 12'd1;
    assign phase_adv = turn_cw_reg ? phase_reg + 3'd1 : phase_reg - 3'd1;
    assign target    = step_item.target_position;
    assign cw_dist   = (target >= current_pos_reg) ? target - current_pos_reg
                                                   : target + spsi_pkg::POS_COUNT - current_pos_reg;
    assign go_cw     = (cw_dist <= spsi_pkg::HALF_TURN);
    assign move_span = go_cw ? cw_dist[1:0] : 2'(spsi_pkg::POS_COUNT - cw_dist);

    always_comb begin
        current_pos_next = current_pos_reg;
        goal_pos_next    = goal_pos_reg;
        moving_next      = moving_reg;
        turn_cw_next     = turn_cw_reg;
        phase_next       = phase_reg;
        steps_left_next  = steps_left_reg;
        tick_count_next  = tick_count_reg;
        coils_next       = coils_reg;
        rejected         = 1'b0;
        if (step_en) begin
            if (step_item.kind == spsi_pkg::KIND_TICK) begin
                if (moving_reg) begin
                    if (tick_inc < limit) begin
                        tick_count_next = tick_inc;
                    end else begin
                        tick_count_next = '0;
                        steps_left_next = steps_dec;
                        if (steps_dec == '0) begin
                            moving_next      = 1'b0;
                            current_pos_next = goal_pos_reg;
                        end else begin
                            phase_next = phase_adv;
                            coils_next = spsi_pkg::coil_pattern(phase_adv);
                        end
                    end
                end
            end else if (moving_reg || !(target inside {[spsi_pkg::POS_MIN:spsi_pkg::POS_MAX]})
                         || target == current_pos_reg) begin
                rejected = 1'b1;
            end else begin
                turn_cw_next    = go_cw;
                phase_next      = go_cw ? spsi_pkg::PHASE_CW : spsi_pkg::PHASE_CCW;
                coils_next      = spsi_pkg::coil_pattern(phase_next);
                steps_left_next = spsi_pkg::half_steps_for(move_span);
                tick_count_next = '0;
                goal_pos_next   = target;
                moving_next     = 1'b1;
            end
        end
        step_result.coils    = coils_next;
        step_result.position = current_pos_next;
        step_result.busy_res = moving_next;
        step_result.rejected = rejected;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg      <= spsi_pkg::PERIOD_RESET;
            current_pos_reg <= spsi_pkg::POS_RESET;
            goal_pos_reg    <= spsi_pkg::POS_RESET;
            moving_reg      <= 1'b0;
            turn_cw_reg     <= 1'b0;
            phase_reg       <= '0;
            steps_left_reg  <= '0;
            tick_count_reg  <= '0;
            coils_reg       <= spsi_pkg::COILS_RESET;
        end else begin
            if (cfg_wr_en) begin
                period_reg <= cfg_wr_data;
            end
            current_pos_reg <= current_pos_next;
            goal_pos_reg    <= goal_pos_next;
            moving_reg      <= moving_next;
            turn_cw_reg     <= turn_cw_next;
            phase_reg       <= phase_next;
            steps_left_reg  <= steps_left_next;
            tick_count_reg  <= tick_count_next;
            coils_reg       <= coils_next;
        end
    end

    a_idle_count_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !moving_reg |-> tick_count_reg == '0)
        else $error("tick count not clear while idle");

    a_moving_has_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        moving_reg |-> steps_left_reg != '0)
        else $error("move in progress with no half steps left");

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        current_pos_reg >= spsi_pkg::POS_MIN && current_pos_reg <= spsi_pkg::POS_MAX)
        else $error("carousel position out of range");

    a_busy_rejects: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && moving_reg && step_item.kind == spsi_pkg::KIND_MOVE |-> step_result.rejected)
        else $error("request accepted during a move");

    a_end_updates_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        moving_reg && !moving_next |=> current_pos_reg == $past(goal_pos_reg))
        else $error("position not updated at end of move");

endmodule

// ===== rtl/core/spsi_out_stage.sv =====
// Result register with valid/ready handshake towards the result channel.
// Depends on spsi_pkg.
`timescale 1ns / 1ps

module spsi_out_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  spsi_pkg::out_item_t load_data,
    output logic                can_load,
    output logic                m_valid,
    input  logic                m_ready,
    output spsi_pkg::out_item_t m_data
);

    logic                valid_reg;
    spsi_pkg::out_item_t data_reg;

    assign can_load = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_data   = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (can_load) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && can_load) begin
            data_reg <= load_data;
        end
    end

endmodule

// ===== rtl/core/six_position_stepper_indexer_core.sv =====
// Top level of the six-position carousel indexer: input register, step logic, result register.
// Depends on spsi_pkg, spsi_motion and spsi_out_stage.
`timescale 1ns / 1ps

// One request (a tick or a move request) is taken per clock cycle while s_ready is high
// and gives exactly one result. A request waits in the input register until the result
// register can load, is applied to the motion state by the single-pass step logic and
// lands in the result register on m_data. A stalled result holds one more request in the
// input register before s_ready drops. half_step_period resets to 1126; the user writes
// it through cfg_wr_en/cfg_wr_data while no request is in flight, unenforced by the block.

module six_position_stepper_indexer_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [spsi_pkg::PERIOD_W-1:0] cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  spsi_pkg::in_item_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output spsi_pkg::out_item_t           m_data
);

    logic                in_valid_reg;
    spsi_pkg::in_item_t  in_data_reg;
    logic                out_can_load;
    logic                advance;
    spsi_pkg::out_item_t step_result;

    assign advance = in_valid_reg && out_can_load;
    assign s_ready = !in_valid_reg || out_can_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    spsi_motion u_motion (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step_en     (advance),
        .step_item   (in_data_reg),
        .step_result (step_result)
    );

    spsi_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance),
        .load_data (step_result),
        .can_load  (out_can_load),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ===== verif/six_position_stepper_indexer_core_tb.sv =====
// Self-checking bench for the six-position carousel indexer core: drives ticks and move requests
// under four handshake idling profiles and checks each result against a built-in motion model.
// Depends on spsi_pkg and six_position_stepper_indexer_core.
`timescale 1ns / 1ps

module six_position_stepper_indexer_core_tb;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int N_PROFILES  = 4;
    localparam int ITEMS_PER_PROFILE = 390;
    localparam int SRC_IDLE_PCT[N_PROFILES]   = '{0, 83, 0, 13};
    localparam int SINK_STALL_PCT[N_PROFILES] = '{0, 0, 83, 13};
    localparam logic [spsi_pkg::POS_W-1:0] BAD_LOW  = 3'd0;
    localparam logic [spsi_pkg::POS_W-1:0] BAD_HIGH = 3'd7;
    localparam logic [spsi_pkg::COILS_W-1:0] HALF_STEP_COILS[8] =
        '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9};

    logic                          aclk;
    logic                          aresetn     = 1'b0;
    logic                          cfg_wr_en   = 1'b0;
    logic [spsi_pkg::PERIOD_W-1:0] cfg_wr_data = '0;
    logic                          s_valid     = 1'b0;
    logic                          s_ready;
    spsi_pkg::in_item_t            s_data      = '0;
    logic                          m_valid;
    logic                          m_ready     = 1'b0;
    spsi_pkg::out_item_t           m_data;

    six_position_stepper_indexer_core u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // motion model state
    logic [spsi_pkg::PERIOD_W-1:0] period_reg  = spsi_pkg::PERIOD_RESET;
    logic [spsi_pkg::POS_W-1:0]    pos_now     = spsi_pkg::POS_RESET;
    logic [spsi_pkg::POS_W-1:0]    pos_goal    = spsi_pkg::POS_RESET;
    logic                          in_motion   = 1'b0;
    logic                          cw_dir      = 1'b0;
    logic [spsi_pkg::PHASE_W-1:0]  phase_idx   = '0;
    logic [spsi_pkg::STEPS_W-1:0]  steps_left  = '0;
    logic [spsi_pkg::PERIOD_W-1:0] tick_cnt    = '0;
    logic [spsi_pkg::COILS_W-1:0]  coils_now   = spsi_pkg::COILS_RESET;

    spsi_pkg::in_item_t  queued_requests[$];
    spsi_pkg::out_item_t predicted_outputs[$];

    int n_pushed       = 0;
    int n_accepted     = 0;
    int n_checked      = 0;
    int moves_done     = 0;
    int fail_count     = 0;
    int cycle_count    = 0;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;

    function automatic int hold_ticks();
        return (period_reg == '0) ? 1 : int'(period_reg);
    endfunction

    function automatic int half_steps_to(input logic [spsi_pkg::POS_W-1:0] goal);
        int cw;
        int span;
        cw   = (int'(goal) + 6 - int'(pos_now)) % 6;
        span = (cw <= 3) ? cw : 6 - cw;
        return (span * 256 / 3) * 8;
    endfunction

    function automatic spsi_pkg::out_item_t indexer_step(input spsi_pkg::in_item_t req);
        spsi_pkg::out_item_t res;
        logic                refused;
        int                  cw;
        refused = 1'b0;
        if (req.kind == spsi_pkg::KIND_TICK) begin
            if (in_motion) begin
                tick_cnt = tick_cnt + 1'b1;
                if (int'(tick_cnt) >= hold_ticks()) begin
                    tick_cnt   = '0;
                    steps_left = steps_left - 1'b1;
                    if (steps_left == '0) begin
                        in_motion = 1'b0;
                        pos_now   = pos_goal;
                        moves_done++;
                    end else begin
                        phase_idx = cw_dir ? phase_idx + 1'b1 : phase_idx - 1'b1;
                        coils_now = HALF_STEP_COILS[phase_idx];
                    end
                end
            end
        end else if (in_motion || req.target_position < spsi_pkg::POS_MIN
                     || req.target_position > spsi_pkg::POS_MAX
                     || req.target_position == pos_now) begin
            refused = 1'b1;
        end else begin
            cw         = (int'(req.target_position) + 6 - int'(pos_now)) % 6;
            cw_dir     = (cw <= 3);
            phase_idx  = cw_dir ? spsi_pkg::PHASE_CW : spsi_pkg::PHASE_CCW;
            steps_left = spsi_pkg::STEPS_W'(half_steps_to(req.target_position));
            tick_cnt   = '0;
            pos_goal   = req.target_position;
            in_motion  = 1'b1;
            coils_now  = HALF_STEP_COILS[phase_idx];
        end
        res.coils    = coils_now;
        res.position = pos_now;
        res.busy_res = in_motion;
        res.rejected = refused;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        fail_count++;
        if (fail_count <= 100)
            $display("[%0t] mismatch on %s: got %0d, expected %0d (result %0d)",
                     $time, what, got, want, n_checked);
    endtask

    task automatic check_result(input spsi_pkg::out_item_t got);
        spsi_pkg::out_item_t want;
        if (predicted_outputs.size() == 0) begin
            report_mismatch("unexpected result", int'(got), 0);
            return;
        end
        want = predicted_outputs.pop_front();
        if (got.coils !== want.coils)
            report_mismatch("coils", int'(got.coils), int'(want.coils));
        if (got.position !== want.position)
            report_mismatch("position", int'(got.position), int'(want.position));
        if (got.busy_res !== want.busy_res)
            report_mismatch("busy_res", int'(got.busy_res), int'(want.busy_res));
        if (got.rejected !== want.rejected)
            report_mismatch("rejected", int'(got.rejected), int'(want.rejected));
        n_checked++;
    endtask

    // driver: present queued requests, predict on acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predicted_outputs.push_back(indexer_step(s_data));
                n_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (queued_requests.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    s_valid <= 1'b1;
                    s_data  <= queued_requests.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: take results, stall at random
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                check_result(m_data);
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, predicted_outputs.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic push_request(input logic kind, input logic [spsi_pkg::POS_W-1:0] target);
        spsi_pkg::in_item_t req;
        req.kind            = kind;
        req.target_position = target;
        queued_requests.push_back(req);
        n_pushed++;
    endtask

    task automatic push_ticks(input int count);
        repeat (count) push_request(spsi_pkg::KIND_TICK, spsi_pkg::POS_W'($urandom_range(7)));
    endtask

    task automatic wait_accepted();
        while (n_accepted != n_pushed)
            @(negedge aclk);
    endtask

    task automatic wait_results();
        wait_accepted();
        while (predicted_outputs.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_period(input logic [spsi_pkg::PERIOD_W-1:0] value);
        wait_results();
        repeat (4) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        period_reg   = value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic int ticks_to_finish();
        return in_motion ? int'(steps_left) * hold_ticks() + 1 : 0;
    endfunction

    task automatic random_sequence();
        logic [spsi_pkg::POS_W-1:0] goal;
        int                         chunk;
        wait_accepted();
        if (in_motion) begin
            // advance a running move in chunks, now and then with a request that bounces while it runs
            chunk = $urandom_range(160, 20);
            if (chunk > ticks_to_finish())
                chunk = ticks_to_finish() + $urandom_range(3);
            push_ticks(chunk / 2);
            if ($urandom_range(3) == 0)
                push_request(spsi_pkg::KIND_MOVE, spsi_pkg::POS_W'($urandom_range(7)));
            push_ticks(chunk - chunk / 2);
            return;
        end
        repeat ($urandom_range(2)) begin
            case ($urandom_range(3))
                0:       push_request(spsi_pkg::KIND_MOVE, BAD_LOW);
                1:       push_request(spsi_pkg::KIND_MOVE, BAD_HIGH);
                2:       push_request(spsi_pkg::KIND_MOVE, pos_now);
                default: push_ticks(1);
            endcase
        end
        do
            goal = spsi_pkg::POS_W'($urandom_range(spsi_pkg::POS_MAX, spsi_pkg::POS_MIN));
        while (goal == pos_now);
        push_request(spsi_pkg::KIND_MOVE, goal);
        push_ticks($urandom_range(40, 1));
    endtask

    function automatic logic [spsi_pkg::PERIOD_W-1:0] pick_period();
        case ($urandom_range(7))
            0, 1, 2, 3: return 16'd1;
            4:          return 16'd0;
            5:          return 16'd2;
            default:    return spsi_pkg::PERIOD_W'($urandom_range(4, 2));
        endcase
    endfunction

    initial begin
        int pushed_base;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: rejections, reset period, extreme periods, period lowered mid-move
        src_idle_pct   = 13;
        sink_stall_pct = 13;
        push_request(spsi_pkg::KIND_MOVE, BAD_LOW);
        push_request(spsi_pkg::KIND_MOVE, BAD_HIGH);
        push_request(spsi_pkg::KIND_MOVE, spsi_pkg::POS_MIN);
        push_ticks(1);
        push_request(spsi_pkg::KIND_MOVE, 3'd2);
        push_request(spsi_pkg::KIND_MOVE, 3'd4);
        push_ticks(3);
        write_period(16'd0);
        push_ticks(2);
        write_period(16'hFFFF);
        push_ticks(3);
        write_period(16'd1);

        // random: move sequences under each idling profile
        for (int p = 0; p < N_PROFILES; p++) begin
            src_idle_pct   = SRC_IDLE_PCT[p];
            sink_stall_pct = SINK_STALL_PCT[p];
            pushed_base    = n_pushed;
            while (n_pushed - pushed_base < ITEMS_PER_PROFILE) begin
                if ($urandom_range(15) == 0)
                    write_period(pick_period());
                random_sequence();
            end
        end

        wait_results();
        repeat (16) @(posedge aclk);
        if (predicted_outputs.size() != 0)
            report_mismatch("results outstanding", predicted_outputs.size(), 0);

        $display("checked %0d results from %0d requests; %0d carousel moves completed",
                 n_checked, n_accepted, moves_done);
        $display("covered reset, extreme and mid-move periods under four idling profiles");
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
